>>> sv/ocd_pkg.sv
// ----------------------------------------------------------------------------
// ocd_pkg
// Shared types and constants for the outline chain-code decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package ocd_pkg;

  localparam int unsigned COORD_W = 16;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned RUN_W   = 6;

  // byte that closes a boundary
  localparam logic [BYTE_W-1:0] CLOSE_CODE = 8'hff;

  // configuration register indexes
  localparam logic CFG_ORIGIN_X = 1'b0;
  localparam logic CFG_ORIGIN_Y = 1'b1;

  // result kinds
  typedef enum logic [1:0] {
    KIND_START = 2'd0,
    KIND_MOVE  = 2'd1,
    KIND_CLOSE = 2'd2,
    KIND_TRUNC = 2'd3
  } kind_t;

  // move directions, top two bits of a move word
  typedef enum logic [1:0] {
    DIR_XP = 2'b00,
    DIR_XN = 2'b01,
    DIR_YP = 2'b10,
    DIR_YN = 2'b11
  } dir_t;

  // decode phase, one-hot
  typedef enum logic [2:0] {
    PH_START_X = 3'b001,
    PH_START_Y = 3'b010,
    PH_MOVES   = 3'b100
  } phase_t;

  typedef struct packed {
    phase_t              phase;
    logic [BYTE_W-1:0]   start_off_x;
    logic [COORD_W-1:0]  cur_x;
    logic [COORD_W-1:0]  cur_y;
  } dec_state_t;

  typedef struct packed {
    kind_t               kind;
    logic [COORD_W-1:0]  x;
    logic [COORD_W-1:0]  y;
    logic                done;
  } result_t;

  // sign-extend a start offset to coordinate width
  function automatic logic [COORD_W-1:0] sext_off(input logic [BYTE_W-1:0] b);
    sext_off = {{(COORD_W-BYTE_W){b[BYTE_W-1]}}, b};
  endfunction

endpackage

`default_nettype wire

>>> sv/outline_chain_code_decoder_core.sv
// ----------------------------------------------------------------------------
// outline_chain_code_decoder_core
// Rebuilds glyph boundary points from a run-length chain-coded byte stream.
// ----------------------------------------------------------------------------
// The decoder takes one outline byte per cycle while the output is not held
// and gives at most one point word per byte: the input register holds the
// byte, the decode stage, whose single 16-bit cursor add sets the clock,
// decodes it and the output register holds the word. A start x byte gives a
// truncation word if it is a last byte, else none; every other byte gives
// one. The input stalls only when the decode stage and output are both held.
// The origin registers are read when a start y byte is decoded and should be
// written only while the block is idle.
`default_nettype none

module outline_chain_code_decoder_core (
  input  logic                             clk,
  input  logic                             rst_n,
  // byte input
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [ocd_pkg::BYTE_W-1:0]       in_code_byte,
  input  logic                             in_last_byte,
  // point output
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [1:0]                       out_kind,
  output logic signed [ocd_pkg::COORD_W-1:0] out_point_x,
  output logic signed [ocd_pkg::COORD_W-1:0] out_point_y,
  output logic                             out_glyph_done,
  // configuration
  input  logic                             cfg_we,
  input  logic                             cfg_index,
  input  logic [ocd_pkg::COORD_W-1:0]      cfg_wdata
);
  import ocd_pkg::*;

  logic               s1_valid_r;
  logic [BYTE_W-1:0]  s1_byte_r;
  logic               s1_last_r;
  logic               s1_go;
  dec_state_t         state_r;
  dec_state_t         state_nxt;
  logic               res_valid;
  result_t            res;
  result_t            out_r;
  logic               out_valid_r;
  logic [COORD_W-1:0] origin_x_r;
  logic [COORD_W-1:0] origin_y_r;

  // handshake
  assign s1_go    = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_go;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_x_r <= '0;
      origin_y_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ORIGIN_X: origin_x_r <= cfg_wdata;
        CFG_ORIGIN_Y: origin_y_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_byte_r <= in_code_byte;
      s1_last_r <= in_last_byte;
    end
  end

  // decode
  ocd_step u_step (
    .state     (state_r),
    .code_byte (s1_byte_r),
    .last_byte (s1_last_r),
    .origin_x  (origin_x_r),
    .origin_y  (origin_y_r),
    .state_nxt (state_nxt),
    .res_valid (res_valid),
    .res       (res)
  );

  // decoder state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.phase       <= PH_START_X;
      state_r.start_off_x <= '0;
      state_r.cur_x       <= '0;
      state_r.cur_y       <= '0;
    end else if (s1_go) begin
      state_r <= state_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_go) begin
      out_valid_r <= res_valid;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && res_valid) begin
      out_r <= res;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_kind       = out_r.kind;
  assign out_point_x    = out_r.x;
  assign out_point_y    = out_r.y;
  assign out_glyph_done = out_r.done;

endmodule

`default_nettype wire

>>> sv/ocd_step.sv
// ----------------------------------------------------------------------------
// ocd_step
// Decode of one outline word: next decoder state and the optional result.
// ----------------------------------------------------------------------------
`default_nettype none

module ocd_step (
  input  ocd_pkg::dec_state_t              state,
  input  logic [ocd_pkg::BYTE_W-1:0]       code_byte,
  input  logic                             last_byte,
  input  logic [ocd_pkg::COORD_W-1:0]      origin_x,
  input  logic [ocd_pkg::COORD_W-1:0]      origin_y,
  output ocd_pkg::dec_state_t              state_nxt,
  output logic                             res_valid,
  output ocd_pkg::result_t                 res
);
  import ocd_pkg::*;

  logic [COORD_W-1:0] run;
  dir_t               dir;

  assign run = {{(COORD_W-RUN_W){1'b0}}, code_byte[RUN_W-1:0]};
  assign dir = dir_t'(code_byte[BYTE_W-1 -: 2]);

  // phase-driven decode
  always_comb begin
    state_nxt = state;
    res_valid = 1'b0;
    res.kind  = KIND_MOVE;
    res.x     = state.cur_x;
    res.y     = state.cur_y;
    res.done  = last_byte;
    case (state.phase)
      PH_START_X: begin
        if (last_byte) begin
          // glyph cut inside the start pair
          res_valid = 1'b1;
          res.kind  = KIND_TRUNC;
          res.x     = '0;
          res.y     = '0;
        end else begin
          state_nxt.start_off_x = code_byte;
          state_nxt.phase       = PH_START_Y;
        end
      end
      PH_START_Y: begin
        state_nxt.cur_x = sext_off(state.start_off_x) + origin_x;
        state_nxt.cur_y = sext_off(code_byte) + origin_y;
        state_nxt.phase = last_byte ? PH_START_X : PH_MOVES;
        res_valid = 1'b1;
        res.kind  = KIND_START;
        res.x     = state_nxt.cur_x;
        res.y     = state_nxt.cur_y;
      end
      default: begin
        res_valid = 1'b1;
        if (code_byte == CLOSE_CODE) begin
          state_nxt.phase = PH_START_X;
          res.kind        = KIND_CLOSE;
        end else begin
          case (dir)
            DIR_XP:  state_nxt.cur_x = state.cur_x + run;
            DIR_XN:  state_nxt.cur_x = state.cur_x - run;
            DIR_YP:  state_nxt.cur_y = state.cur_y + run;
            default: state_nxt.cur_y = state.cur_y - run;
          endcase
          if (last_byte) begin
            state_nxt.phase = PH_START_X;
          end
          res.kind = KIND_MOVE;
          res.x    = state_nxt.cur_x;
          res.y    = state_nxt.cur_y;
        end
      end
    endcase
  end

endmodule

`default_nettype wire

>>> sv/ocd_checker.sv
// ----------------------------------------------------------------------------
// ocd_checker
// Port-level checks for the outline chain-code decoder, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module ocd_checker (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  input  logic                             in_ready,
  input  logic                             out_valid,
  input  logic                             out_ready,
  input  logic [1:0]                       out_kind,
  input  logic signed [ocd_pkg::COORD_W-1:0] out_point_x,
  input  logic signed [ocd_pkg::COORD_W-1:0] out_point_y,
  input  logic                             out_glyph_done
);
  import ocd_pkg::*;

  // a held word keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_kind) &&
      $stable(out_point_x) && $stable(out_point_y) && $stable(out_glyph_done))
    else $error("output word changed while stalled");

  // a truncated start always ends the glyph at the zero point
  a_trunc: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_TRUNC |->
      out_glyph_done && out_point_x == '0 && out_point_y == '0)
    else $error("bad truncation word");

  // nothing comes out right after reset
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

  // with the output free and the input empty, the block takes a byte
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid && $past(!in_valid) && $past(rst_n) |-> in_ready)
    else $error("input stalled with nothing in flight");

endmodule

bind outline_chain_code_decoder_core ocd_checker u_ocd_checker (.*);

`default_nettype wire

>>> test/outline_chain_code_decoder_core_tb.sv
// ----------------------------------------------------------------------------
// outline_chain_code_decoder_core_tb
// Self-checking bench for the outline chain-code decoder. Byte words go in
// through a valid/ready sender with random gaps. Each accepted word is run
// through a local decoder model that queues the point words it should give.
// A monitor compares every point word that leaves the block with the oldest
// queued one. The bench covers directed corner cases, origin extremes, a long
// output hold-off, a drain pause and a long randomized run with origin changes.
// ----------------------------------------------------------------------------
`default_nettype none

module outline_chain_code_decoder_core_tb;
  import ocd_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_CYCLES = 4000;
  localparam int HOLD_CYCLES     = 300;
  localparam int SETTLE_CYCLES   = 8;
  localparam int RANDOM_WORDS    = 1800;

  // clock and reset
  logic clk = 1'b0;
  logic rst_n = 1'b0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // block ports
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [BYTE_W-1:0]    in_code_byte = '0;
  logic                 in_last_byte = 1'b0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [1:0]           out_kind;
  logic signed [COORD_W-1:0] out_point_x;
  logic signed [COORD_W-1:0] out_point_y;
  logic                 out_glyph_done;
  logic                 cfg_we = 1'b0;
  logic                 cfg_index = CFG_ORIGIN_X;
  logic [COORD_W-1:0]   cfg_wdata = '0;

  outline_chain_code_decoder_core dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_code_byte   (in_code_byte),
    .in_last_byte   (in_last_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_kind       (out_kind),
    .out_point_x    (out_point_x),
    .out_point_y    (out_point_y),
    .out_glyph_done (out_glyph_done),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata)
  );

  // decoder model state
  phase_t             mdl_phase = PH_START_X;
  logic [BYTE_W-1:0]  mdl_off_x = '0;
  logic [COORD_W-1:0] mdl_cur_x = '0;
  logic [COORD_W-1:0] mdl_cur_y = '0;
  logic [COORD_W-1:0] mdl_org_x = '0;
  logic [COORD_W-1:0] mdl_org_y = '0;

  result_t pending_points[$];
  result_t want_pt;
  int      errors = 0;
  int      words_sent = 0;

  // stimulus shaping
  logic calm = 1'b0;
  logic stall_tog = 1'b0;
  logic stall_seen = 1'b0;
  int   hold_left = 0;
  int   idle_count = 0;

  // append one expected point at the tail of the queue
  task automatic queue_point(input result_t pt);
    pending_points.insert(pending_points.size(), pt);
  endtask

  // model of one decoded word, queues the point it gives
  task automatic decode_word(input logic [BYTE_W-1:0] b, input logic last);
    result_t pt;
    logic [COORD_W-1:0] run;
    pt.done = last;
    case (mdl_phase)
      PH_START_X: begin
        if (last) begin
          pt.kind = KIND_TRUNC;
          pt.x = '0;
          pt.y = '0;
          queue_point(pt);
        end else begin
          mdl_off_x = b;
          mdl_phase = PH_START_Y;
        end
      end
      PH_START_Y: begin
        mdl_cur_x = {{(COORD_W-BYTE_W){mdl_off_x[BYTE_W-1]}}, mdl_off_x} + mdl_org_x;
        mdl_cur_y = {{(COORD_W-BYTE_W){b[BYTE_W-1]}}, b} + mdl_org_y;
        mdl_phase = last ? PH_START_X : PH_MOVES;
        pt.kind = KIND_START;
        pt.x = mdl_cur_x;
        pt.y = mdl_cur_y;
        queue_point(pt);
      end
      default: begin
        if (b == CLOSE_CODE) begin
          mdl_phase = PH_START_X;
          pt.kind = KIND_CLOSE;
        end else begin
          run = COORD_W'(b[RUN_W-1:0]);
          case (dir_t'(b[7:6]))
            DIR_XP: mdl_cur_x = mdl_cur_x + run;
            DIR_XN: mdl_cur_x = mdl_cur_x - run;
            DIR_YP: mdl_cur_y = mdl_cur_y + run;
            default: mdl_cur_y = mdl_cur_y - run;
          endcase
          if (last) mdl_phase = PH_START_X;
          pt.kind = KIND_MOVE;
        end
        pt.x = mdl_cur_x;
        pt.y = mdl_cur_y;
        queue_point(pt);
      end
    endcase
  endtask

  // offer one byte word and wait until it is taken
  task automatic send_word(input logic [BYTE_W-1:0] b, input logic last);
    if (!calm && $urandom_range(99) < 6) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_code_byte <= b;
    in_last_byte <= last;
    do @(posedge clk); while (!in_ready);
    decode_word(b, last);
    words_sent++;
  endtask

  // stop offering and wait until every queued point has come out
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_points.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // write both origin registers, block must be idle
  task automatic set_origins(input logic [COORD_W-1:0] ox, input logic [COORD_W-1:0] oy);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_ORIGIN_X;
    cfg_wdata <= ox;
    @(posedge clk);
    mdl_org_x = ox;
    cfg_index <= CFG_ORIGIN_Y;
    cfg_wdata <= oy;
    @(posedge clk);
    mdl_org_y = oy;
    cfg_we <= 1'b0;
  endtask

  function automatic logic [COORD_W-1:0] pick_origin();
    case ($urandom_range(7))
      0: pick_origin = 16'h7fff;
      1: pick_origin = 16'h8000;
      2: pick_origin = 16'h0000;
      3: pick_origin = 16'hffff;
      default: pick_origin = COORD_W'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic logic [BYTE_W-1:0] pick_move();
    logic [1:0] dir;
    logic [5:0] run;
    dir = 2'($urandom_range(3));
    run = 6'($urandom_range(63));
    if (dir == 2'b11 && run == 6'h3f) run = 6'h3e;
    pick_move = {dir, run};
  endfunction

  // one well-formed glyph with random content and a random way of ending
  task automatic send_glyph(input int max_moves);
    int n_bound;
    int n_moves;
    int ending;
    bit last_bound;
    n_bound = $urandom_range(1, 3);
    for (int i = 0; i < n_bound; i++) begin
      last_bound = (i == n_bound - 1);
      ending = last_bound ? $urandom_range(9) : 9;
      if (ending == 0) begin
        send_word(8'($urandom_range(255)), 1'b1);
        return;
      end
      send_word(8'($urandom_range(255)), 1'b0);
      if (ending == 1) begin
        send_word(8'($urandom_range(255)), 1'b1);
        return;
      end
      send_word(8'($urandom_range(255)), 1'b0);
      n_moves = $urandom_range(0, max_moves);
      if (ending == 2 && n_moves == 0) n_moves = 1;
      for (int m = 0; m < n_moves; m++)
        send_word(pick_move(), (ending == 2) && (m == n_moves - 1));
      if (ending != 2) send_word(CLOSE_CODE, last_bound);
    end
  endtask

  // broken stream: random bytes and flags, then a last word to resync
  task automatic send_noise();
    int n;
    n = $urandom_range(1, 8);
    for (int i = 0; i < n; i++)
      send_word(8'($urandom_range(255)), $urandom_range(4) == 0);
    send_word(8'($urandom_range(255)), 1'b1);
  endtask

  // corner cases at zero origin
  task automatic test_directed();
    // every direction, zero and full runs, then close
    send_word(8'h7f, 1'b0);
    send_word(8'h80, 1'b0);
    send_word(8'h3f, 1'b0);
    send_word(8'h40, 1'b0);
    send_word(8'h7f, 1'b0);
    send_word(8'hbf, 1'b0);
    send_word(8'hc1, 1'b0);
    send_word(8'h00, 1'b0);
    send_word(CLOSE_CODE, 1'b0);
    // glyph cut after start x
    send_word(8'h12, 1'b1);
    // close code as both offsets, glyph ends on start y
    send_word(CLOSE_CODE, 1'b0);
    send_word(CLOSE_CODE, 1'b1);
    // glyph ends on a move
    send_word(8'h00, 1'b0);
    send_word(8'h01, 1'b0);
    send_word(8'h85, 1'b1);
    // glyph ends on a close
    send_word(8'h10, 1'b0);
    send_word(8'h20, 1'b0);
    send_word(CLOSE_CODE, 1'b1);
    drain();
  endtask

  // origin extremes with wrapping starts and moves
  task automatic test_origin_extremes();
    set_origins(16'h7fff, 16'h8000);
    send_word(8'h7f, 1'b0);
    send_word(8'h80, 1'b0);
    send_word(8'h3f, 1'b0);
    send_word(8'hff - 8'h01 - 8'h3f + 8'h3f, 1'b0);
    send_word(CLOSE_CODE, 1'b1);
    drain();
    set_origins(16'h8000, 16'h7fff);
    send_word(8'h80, 1'b0);
    send_word(8'h7f, 1'b0);
    send_word(8'h41, 1'b0);
    send_word(8'hbf, 1'b1);
    drain();
  endtask

  // receiver holds off while the sender keeps offering
  task automatic test_backpressure();
    calm <= 1'b1;
    stall_tog <= ~stall_tog;
    for (int i = 0; i < 6; i++) send_glyph(12);
    drain();
    calm <= 1'b0;
  endtask

  // sender pauses mid-glyph until every point has come out
  task automatic test_pause();
    send_word(8'h05, 1'b0);
    drain();
    send_word(8'hfb, 1'b0);
    send_word(8'h22, 1'b0);
    drain();
    send_word(8'he0, 1'b0);
    send_word(CLOSE_CODE, 1'b1);
    drain();
  endtask

  // long random run split into origin settings, one stretch without gaps
  task automatic test_random();
    int target;
    for (int ph = 0; ph < 6; ph++) begin
      set_origins(pick_origin(), pick_origin());
      if (ph == 2) calm <= 1'b1;
      target = words_sent + RANDOM_WORDS / 6;
      while (words_sent < target) begin
        if ($urandom_range(99) < 15) send_noise();
        else send_glyph($urandom_range(99) < 10 ? 40 : 8);
      end
      drain();
      if (ph == 2) calm <= 1'b0;
    end
  endtask

  // receiver: random stalls, long hold-off on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (stall_tog != stall_seen) begin
      stall_seen <= stall_tog;
      hold_left  <= HOLD_CYCLES;
      out_ready  <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= calm || ($urandom_range(99) >= 6);
    end
  end

  // point word check against the oldest queued point
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_points.size() == 0) begin
        $error("unexpected point word: kind %0d x %0d y %0d",
               out_kind, out_point_x, out_point_y);
        errors++;
      end else begin
        want_pt = pending_points.pop_front();
        if (out_kind !== want_pt.kind) begin
          $error("kind: expected %0d, got %0d", want_pt.kind, out_kind);
          errors++;
        end
        if (out_point_x !== want_pt.x) begin
          $error("point_x: expected %0d, got %0d", $signed(want_pt.x), out_point_x);
          errors++;
        end
        if (out_point_y !== want_pt.y) begin
          $error("point_y: expected %0d, got %0d", $signed(want_pt.y), out_point_y);
          errors++;
        end
        if (out_glyph_done !== want_pt.done) begin
          $error("glyph_done: expected %0d, got %0d", want_pt.done, out_glyph_done);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_count <= 0;
      end else if (idle_count >= WATCHDOG_CYCLES) begin
        $display("CHECKS FAILED");
        $finish;
      end else begin
        idle_count <= idle_count + 1;
      end
    end
  end

  // test sequence
  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_origin_extremes();
    test_backpressure();
    test_pause();
    test_random();
    drain();
    if (pending_points.size() != 0) begin
      $error("%0d point words never came out", pending_points.size());
      errors++;
    end
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

>>> sim.f
sv/ocd_pkg.sv
sv/ocd_step.sv
sv/outline_chain_code_decoder_core.sv
sv/ocd_checker.sv
test/outline_chain_code_decoder_core_tb.sv
